[design/hbac_pkg.sv]
// Shared types, field widths and the artifact colour table for the hires byte decoder.
package hbac_pkg;

    localparam int unsigned COLUMN_W    = 6;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PIXELS      = 7;
    localparam int unsigned RGB_W       = 24;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = PIXELS * RGB_W;

    localparam int unsigned GROUP_BIT = 7;
    localparam int unsigned CARRY_BIT = 6;

    typedef logic [RGB_W-1:0] t_rgb;

    localparam t_rgb RGB_BLACK  = 24'h000000;
    localparam t_rgb RGB_WHITE  = 24'hffffff;
    localparam t_rgb RGB_GREEN  = 24'h14f53c;
    localparam t_rgb RGB_VIOLET = 24'hff44fd;
    localparam t_rgb RGB_ORANGE = 24'hff6a3c;
    localparam t_rgb RGB_BLUE   = 24'h14cffd;

    // Index is {phase, group, current, previous}
    function automatic t_rgb palette(input logic [3:0] idx);
        t_rgb c;
        case (idx)
            4'd0, 4'd4, 4'd8, 4'd12:  c = RGB_BLACK;
            4'd3, 4'd7, 4'd11, 4'd15: c = RGB_WHITE;
            4'd1, 4'd10:              c = RGB_GREEN;
            4'd2, 4'd9:               c = RGB_VIOLET;
            4'd5, 4'd14:              c = RGB_ORANGE;
            4'd6, 4'd13:              c = RGB_BLUE;
            default:                  c = RGB_BLACK;
        endcase
        return c;
    endfunction

endpackage

[design/hbac_decode.sv]
// Per-pixel colour lookup: seven lanes, each chained to the pixel on its left.
module hbac_decode (
    input  logic                               i_parity,
    input  logic [hbac_pkg::BYTE_W-1:0]        i_byte,
    input  logic                               i_carry,
    output logic [hbac_pkg::OUT_TDATA_W-1:0]   o_pixels
);

    logic [hbac_pkg::PIXELS-1:0] prev;

    assign prev = {i_byte[hbac_pkg::PIXELS-2:0], i_carry};

    for (genvar g = 0; g < hbac_pkg::PIXELS; g++) begin : g_lane
        logic       phase;
        logic [3:0] idx;

        // column*7+i has the parity of column+i
        assign phase     = i_parity ^ 1'(g % 2);
        assign idx       = {phase, i_byte[hbac_pkg::GROUP_BIT], i_byte[g], prev[g]};
        assign o_pixels[g*hbac_pkg::RGB_W +: hbac_pkg::RGB_W] = hbac_pkg::palette(idx);
    end

endmodule

[design/hires_byte_artifact_color_decoder.sv]
// Top level: input register, colour lookup and result register for hires video bytes.
//
// Usage: feed one transaction per video byte on the slave channel; tdata carries
// the byte column (only its parity matters) and the byte itself. Each accepted
// transaction yields exactly one master transaction with seven 24-bit RGB pixels,
// pixel 0 in the lowest bits.
// A result passes through the input register, then the result register, before
// it is presented on the master channel.
// Throughput: one byte per cycle, limited by the single result register and its
// downstream handshake.
// Bit 6 of each byte is carried over as the left neighbour of pixel 0 of the next
// byte; nothing clears it at a line start. Reset empties both registers and
// clears the carried pixel.
// When the receiver stalls, the result register holds; the input register keeps
// accepting until it too holds an item, then o_s_tready drops.
module hires_byte_artifact_color_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [5:0] column, [13:6] video_byte, [15:14] zero
    input  logic [hbac_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [23:0] pixel_0, [47:24] pixel_1, ... [167:144] pixel_6
    output logic [hbac_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    logic                                r_s1_valid;
    logic                                r_s1_parity;
    logic [hbac_pkg::BYTE_W-1:0]         r_s1_byte;
    logic                                r_carry;
    logic                                r_s2_valid;
    logic [hbac_pkg::OUT_TDATA_W-1:0]    r_s2_pixels;
    logic [hbac_pkg::OUT_TDATA_W-1:0]    n_s2_pixels;
    logic                                s2_ready;
    logic                                s1_move;

    assign s2_ready   = !r_s2_valid || i_m_tready;
    assign s1_move    = r_s1_valid && s2_ready;
    assign o_s_tready = !r_s1_valid || s2_ready;

    hbac_decode u_decode (
        .i_parity (r_s1_parity),
        .i_byte   (r_s1_byte),
        .i_carry  (r_carry),
        .o_pixels (n_s2_pixels)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_carry    <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            // advance the carried pixel only as a byte leaves for the result register
            if (s1_move) begin
                r_carry <= r_s1_byte[hbac_pkg::CARRY_BIT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_parity <= i_s_tdata[0];
            r_s1_byte   <= i_s_tdata[hbac_pkg::COLUMN_W +: hbac_pkg::BYTE_W];
        end
        if (s1_move) begin
            r_s2_pixels <= n_s2_pixels;
        end
    end

    assign o_m_tvalid = r_s2_valid;
    assign o_m_tdata  = r_s2_pixels;

    a_carry_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_move |=> $stable(r_carry))
        else $error("carried pixel changed without a byte moving on");

    a_move_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> o_m_tvalid)
        else $error("result register empty after a byte moved in");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !r_s1_valid && !r_carry)
        else $error("pipeline not empty after reset");

endmodule
